FILE: hdl/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Request types, register indexes and the substitution table.
// ----------------------------------------------------------------------------
`default_nettype none
package aes128_pkg;

  typedef struct packed {
    logic [63:0] plain_half;
    logic        second_half;
  } in_req_t;

  typedef struct packed {
    logic [63:0] cipher_half;
    logic        block_end;
  } out_req_t;

  localparam logic [1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [1:0] REG_KEY_LOWER = 2'd1;

  localparam logic [3:0] LAST_ROUND = 4'd10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Column-serial AES-128 core fed and drained in 64-bit halves.
// ----------------------------------------------------------------------------
// After the second half the rounds run, then the two output halves are sent.
// No new block is taken until both output halves of the last have gone out.
// One state column and one key word per cycle pass through four S-boxes each.
// Reset clears the key registers, the held-half flag and the control state.
`default_nettype none
module aes128_block_encrypt (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire aes128_pkg::in_req_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output aes128_pkg::out_req_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_data
);
  import aes128_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT0 = 2'd2;
  localparam logic [1:0] ST_OUT1 = 2'd3;

  logic [1:0]   state_r;
  logic [63:0]  key_upper_r, key_lower_r, held_r;
  logic         waiting_r;
  logic [127:0] st_r, nx_r, key_r;
  logic [7:0]   rcon_r;
  logic [3:0]   rnd_r;
  logic [1:0]   col_r;

  logic [7:0]   a [4];
  logic [7:0]   all_x;
  logic [31:0]  mixed, res, kw, kprev, kcur, k3, subrot;
  logic [1:0]   idx [4];
  logic [1:0]   pcol;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT0) || (state_r == ST_OUT1);
  assign out_data.cipher_half = (state_r == ST_OUT1) ? st_r[63:0] : st_r[127:64];
  assign out_data.block_end   = (state_r == ST_OUT1);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      idx[r] = col_r + 2'(r);
      a[r]   = SBOX[st_r[127 - 8 * (4 * idx[r] + r) -: 8]];
    end
    all_x = a[0] ^ a[1] ^ a[2] ^ a[3];
    mixed = {a[0] ^ all_x ^ xtime(a[0] ^ a[1]), a[1] ^ all_x ^ xtime(a[1] ^ a[2]),
             a[2] ^ all_x ^ xtime(a[2] ^ a[3]), a[3] ^ all_x ^ xtime(a[3] ^ a[0])};
    k3     = key_r[31:0];
    subrot = {SBOX[k3[23:16]] ^ rcon_r, SBOX[k3[15:8]], SBOX[k3[7:0]], SBOX[k3[31:24]]};
    pcol   = col_r - 2'd1;
    kcur   = key_r[127 - 32 * col_r -: 32];
    kprev  = key_r[127 - 32 * pcol -: 32];
    kw     = kcur ^ ((col_r == 2'd0) ? subrot : kprev);
    res    = ((rnd_r == LAST_ROUND) ? {a[0], a[1], a[2], a[3]} : mixed) ^ kw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_upper_r <= '0;
      key_lower_r <= '0;
      waiting_r   <= 1'b0;
      held_r      <= '0;
      rnd_r       <= '0;
      col_r       <= '0;
      rcon_r      <= 8'h01;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KEY_UPPER: key_upper_r <= cfg_data;
          REG_KEY_LOWER: key_lower_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_data.second_half) begin
              held_r    <= in_data.plain_half;
              waiting_r <= 1'b1;
            end else if (waiting_r) begin
              st_r      <= {held_r, in_data.plain_half} ^ {key_upper_r, key_lower_r};
              key_r     <= {key_upper_r, key_lower_r};
              rcon_r    <= 8'h01;
              rnd_r     <= 4'd1;
              col_r     <= 2'd0;
              waiting_r <= 1'b0;
              state_r   <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          key_r[127 - 32 * col_r -: 32] <= kw;
          nx_r[127 - 32 * col_r -: 32]  <= res;
          col_r <= col_r + 2'd1;
          if (col_r == 2'd3) begin
            st_r   <= {nx_r[127:32], res};
            rcon_r <= xtime(rcon_r);
            if (rnd_r == LAST_ROUND) begin
              state_r <= ST_OUT0;
            end else begin
              rnd_r <= rnd_r + 4'd1;
            end
          end
        end
        ST_OUT0: begin
          if (!out_stall) begin
            state_r <= ST_OUT1;
          end
        end
        ST_OUT1: begin
          if (!out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Sends plaintext halves under several keys, predicts the ciphertext with an
// independent AES-128 model and compares every output request with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import aes128_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_req_t in_data;
  logic out_valid;
  logic out_stall;
  out_req_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;

  aes128_block_encrypt i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic [7:0] sub_table [256];
  logic [63:0] key_hi, key_lo, held_half;
  logic half_held;
  out_req_t cipher_queue[$];
  int mismatches;
  int idle_pct_in, idle_pct_out;
  int quiet_cycles;
  bit hold_receiver;
  bit timed_out;

  typedef struct {
    logic [63:0] plain;
    logic        second;
    bit          known;
    logic [63:0] c0;
    logic [63:0] c1;
  } vector_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] pt, input logic [127:0] key);
    logic [7:0] w [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] tw [4];
    logic [7:0] tmp, rc, a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      w[i] = key[127 - 8 * i -: 8];
      s[i] = pt[127 - 8 * i -: 8] ^ w[i];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tw[j] = w[i - 4 + j];
      if (i % 16 == 0) begin
        tmp = tw[0];
        tw[0] = sub_table[tw[1]] ^ rc;
        tw[1] = sub_table[tw[2]];
        tw[2] = sub_table[tw[3]];
        tw[3] = sub_table[tmp];
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) w[i + j] = w[i - 16 + j] ^ tw[j];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) t[4 * c + q] = sub_table[s[4 * ((c + q) % 4) + q]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4 * c]     = a0 ^ al ^ gf_double(a0 ^ a1);
          t[4 * c + 1] = a1 ^ al ^ gf_double(a1 ^ a2);
          t[4 * c + 2] = a2 ^ al ^ gf_double(a2 ^ a3);
          t[4 * c + 3] = a3 ^ al ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16 * r + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  // Tracks the held half and queues the two ciphertext halves on a completed block.
  task automatic predict_request(input in_req_t req);
    logic [127:0] ct;
    out_req_t r;
    if (!req.second_half) begin
      held_half = req.plain_half;
      half_held = 1'b1;
    end else if (half_held) begin
      ct = aes_encrypt({held_half, req.plain_half}, {key_hi, key_lo});
      r.cipher_half = ct[127:64];
      r.block_end = 1'b0;
      cipher_queue.push_back(r);
      r.cipher_half = ct[63:0];
      r.block_end = 1'b1;
      cipher_queue.push_back(r);
      half_held = 1'b0;
    end
  endtask

  task automatic send_request(input logic [63:0] plain, input logic second);
    in_req_t req;
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req.plain_half = plain;
    req.second_half = second;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
  endtask

  task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_KEY_UPPER) key_hi = value;
    else if (idx == REG_KEY_LOWER) key_lo = value;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_blocks(input int count);
    logic [63:0] a, b;
    for (int n = 0; n < count; n++) begin
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(9))
        0: send_request(a, 1'b1);
        1: begin
          send_request(a, 1'b0);
          send_request(b, 1'b0);
        end
        default: begin
          send_request(a, 1'b0);
          send_request(b, 1'b1);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (cipher_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output request %h end=%b", out_data.cipher_half,
                     out_data.block_end);
        end else begin
          if (out_data !== cipher_queue[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h end=%b, got %h end=%b",
                       cipher_queue[0].cipher_half, cipher_queue[0].block_end,
                       out_data.cipher_half, out_data.block_end);
          end
          void'(cipher_queue.pop_front());
        end
      end
      out_stall <= hold_receiver || ($urandom_range(99) < idle_pct_out);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    vector_t vectors [$];
    vector_t v;
    for (int i = 0; i < 256; i++) sub_table[i] = SBOX[i];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    key_hi = '0;
    key_lo = '0;
    held_half = '0;
    half_held = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    hold_receiver = 1'b0;
    idle_pct_in = 33;
    idle_pct_out = 33;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero key after reset: a lone second half is ignored, then the all-zero block and an all-ones block.
    vectors.push_back('{64'h1, 1'b1, 1'b0, 64'h0, 64'h0});
    vectors.push_back('{64'h0, 1'b0, 1'b0, 64'h0, 64'h0});
    vectors.push_back('{64'h0, 1'b1, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    vectors.push_back('{'1, 1'b0, 1'b0, 64'h0, 64'h0});
    vectors.push_back('{'1, 1'b1, 1'b0, 64'h0, 64'h0});
    // A newer first half replaces the one held.
    vectors.push_back('{64'h0123456789abcdef, 1'b0, 1'b0, 64'h0, 64'h0});
    vectors.push_back('{64'h8000000000000000, 1'b0, 1'b0, 64'h0, 64'h0});
    vectors.push_back('{64'h0000000000000001, 1'b1, 1'b0, 64'h0, 64'h0});
    foreach (vectors[i]) begin
      v = vectors[i];
      if (v.known && v.second && half_held) begin
        if (aes_encrypt({held_half, v.plain}, {key_hi, key_lo}) !== {v.c0, v.c1}) begin
          mismatches++;
          $display("model disagrees with known ciphertext %h%h", v.c0, v.c1);
        end
      end
      send_request(v.plain, v.second);
    end
    wait_drained();

    // Standard test vector key, written out of order with an unused index.
    write_key(REG_UNUSED, '1);
    write_key(REG_KEY_LOWER, 64'habf7158809cf4f3c);
    write_key(REG_KEY_UPPER, 64'h2b7e151628aed2a6);
    send_request(64'h3243f6a8885a308d, 1'b0);
    send_request(64'h313198a2e0370734, 1'b1);
    send_request(64'h00112233_44556677, 1'b0);
    wait_drained();
    // Key change between halves: the key in force at the second half applies.
    write_key(REG_KEY_UPPER, '1);
    write_key(REG_KEY_LOWER, '1);
    send_request(64'h8899aabbccddeeff, 1'b1);
    send_request(64'h0, 1'b1);
    random_blocks(60);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering requests.
    fork
      begin
        hold_receiver = 1'b1;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
      random_blocks(20);
    join
    wait_drained();

    // Full-rate stretch with no idling.
    idle_pct_in = 0;
    idle_pct_out = 0;
    write_key(REG_KEY_UPPER, {$urandom, $urandom});
    write_key(REG_KEY_LOWER, {$urandom, $urandom});
    random_blocks(80);
    wait_drained();

    idle_pct_in = 33;
    idle_pct_out = 33;
    for (int p = 0; p < 3; p++) begin
      write_key(REG_KEY_UPPER, {$urandom, $urandom});
      write_key(REG_KEY_LOWER, {$urandom, $urandom});
      random_blocks(60);
      wait_drained();
    end

    if (mismatches == 0 && cipher_queue.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: aes128_block_encrypt.f
hdl/aes128_pkg.sv
hdl/aes128_block_encrypt.sv
tb/tb_top.sv
